// ----- rtl/fbh_pkg.sv -----
// Package with the shared types, codes and sizes of the fixed-bin histogram.
`timescale 1ns / 1ps
package fbh_pkg;
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_SUMMARY = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] CFG_ORIGIN = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_BINS   = 2'd2;

    localparam int CFG_DATA_BITS = 32;
    localparam int QUOT_BITS     = 33;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] sample;
        logic [7:0]         bin_select;
    } item_t;

    typedef struct packed {
        logic [31:0]        bin_value;
        logic               range_error;
        logic [31:0]        underflow_total;
        logic [31:0]        overflow_total;
        logic signed [31:0] smallest_sample;
        logic signed [31:0] largest_sample;
        logic               empty_flag;
        logic [31:0]        sum_of_bins;
        logic [31:0]        peak_bin;
        logic [31:0]        floor_bin;
    } result_t;

    // Request from the control sequencer to the bin divider.
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [30:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } div_rsp_t;
endpackage

// ----- rtl/fbh_if.sv -----
// Valid/ready channel interface that carries one payload per transfer.
`timescale 1ns / 1ps
interface fbh_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/fbh_divider.sv -----
// Restoring divider that yields one quotient bit per cycle for the bin index.
`timescale 1ns / 1ps
module fbh_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  fbh_pkg::div_req_t   req,
    output fbh_pkg::div_rsp_t   rsp
);
    localparam int CNT_BITS = $clog2(fbh_pkg::QUOT_BITS + 1);

    logic [32:0]         quot_reg;
    logic [32:0]         quot_next;
    logic [31:0]         rem_reg;
    logic [31:0]         rem_next;
    logic [30:0]         dvs_reg;
    logic [30:0]         dvs_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [32:0]         trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[32]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_BITS'(fbh_pkg::QUOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, dvs_reg})
            begin
                rem_next  = 32'(trial - {2'b00, dvs_reg});
                quot_next = {quot_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[31:0];
                quot_next = {quot_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (rst_n && busy_reg)
            assert (rem_reg < {1'b0, dvs_reg})
            else $error("Partial remainder reached the divisor.");
    end
endmodule

// ----- rtl/fbh_bin_ram.sv -----
// Synchronous single-port bin count memory with a registered read.
`timescale 1ns / 1ps
module fbh_bin_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/fixed_bin_histogram_core.sv -----
// Top level of the fixed-bin histogram: control sequencer, bin memory and divider.
// An add runs the sample through the bit-serial divider, then reads its bin and writes it
// back incremented, or skips both when the sample falls below or above the bins;
// a read fetches one bin or flags a range error; a summary walks the bins in use;
// a clear sweeps all MAX_BINS bins. The core takes one item at a time, only when idle.
// After reset a clearing pass zeroes the bin memory before any item is taken;
// every write to the origin, width or bin count starts the same pass.
`timescale 1ns / 1ps
module fixed_bin_histogram_core #(
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fbh_if.sink                                 in_ch,
    fbh_if.source                               out_ch,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [fbh_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NW   = $clog2(MAX_BINS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_ARD   = 4'd3;
    localparam logic [3:0] ST_AWR   = 4'd4;
    localparam logic [3:0] ST_RRD   = 4'd5;
    localparam logic [3:0] ST_RDAT  = 4'd6;
    localparam logic [3:0] ST_SWALK = 4'd7;
    localparam logic [3:0] ST_SLAST = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic signed [31:0]     origin_reg;
    logic [30:0]            width_reg;
    logic [8:0]             nbins_reg;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic signed [31:0]     low_reg, low_next, high_reg, high_next;
    logic                   empty_reg, empty_next;
    logic [COUNT_BITS-1:0]  below_reg, below_next, above_reg, above_next;
    logic [31:0]            sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  peak_reg, peak_next, flo_reg, flo_next;
    logic                   first_reg, first_next;
    fbh_pkg::item_t         item_reg;
    fbh_pkg::result_t       res_reg, res_next;
    logic                   ovalid_reg, ovalid_next;
    logic                   clear_req;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata;
    fbh_pkg::div_req_t      dreq;
    fbh_pkg::div_rsp_t      drsp;

    logic [NW-1:0]          n_eff;
    logic [30:0]            w_eff;
    logic signed [33:0]     diff;
    logic [41:0]            span;
    logic [31:0]            c32;
    logic [32:0]            sum_add;

    function automatic logic [31:0] clamp32(input logic [COUNT_BITS-1:0] c);
        logic [31:0] r;
        r = 32'(c);
        if (COUNT_BITS > 32)
        begin
            if ((c >> (COUNT_BITS > 32 ? 32 : 0)) != '0 && COUNT_BITS > 32)
                r = '1;
        end
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == CMAX) ? c : c + 1'b1;
    endfunction

    fbh_bin_ram #(.DEPTH(MAX_BINS), .WIDTH(COUNT_BITS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fbh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign clear_req = cfg_we && (cfg_index == fbh_pkg::CFG_ORIGIN
        || cfg_index == fbh_pkg::CFG_WIDTH || cfg_index == fbh_pkg::CFG_BINS);

    always_comb
    begin
        n_eff = (32'(nbins_reg) > 32'(MAX_BINS)) ? NW'(MAX_BINS) : NW'(nbins_reg);
        w_eff = (width_reg == '0) ? 31'd1 : width_reg;
    end

    assign diff    = 34'(item_reg.sample) - 34'(origin_reg);
    assign span    = 42'(n_eff) * 42'(w_eff);
    assign c32     = clamp32(ram_rdata);
    assign sum_add = {1'b0, sum_reg} + {1'b0, c32};

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        empty_next  = empty_reg;
        below_next  = below_reg;
        above_next  = above_reg;
        sum_next    = sum_reg;
        peak_next   = peak_reg;
        flo_next    = flo_reg;
        first_next  = first_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        ram_we      = 1'b0;
        ram_addr    = ptr_reg;
        ram_wdata   = '0;
        dreq.start    = 1'b0;
        dreq.dividend = 33'(diff);
        dreq.divisor  = w_eff;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == AW'(MAX_BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_ch.valid && !ovalid_next)
                begin
                    unique case (in_ch.payload.opcode)
                        fbh_pkg::OP_ADD:     state_next = ST_DIV;
                        fbh_pkg::OP_READ:    state_next = ST_RRD;
                        fbh_pkg::OP_SUMMARY: state_next = ST_SWALK;
                        default:             state_next = ST_SWEEP;
                    endcase
                    ptr_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                    first_next = 1'b1;
                    if (in_ch.payload.opcode == fbh_pkg::OP_CLEAR)
                    begin
                        low_next   = '0;
                        high_next  = '0;
                        empty_next = 1'b1;
                        below_next = '0;
                        above_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                if (!cnt_reg[0])
                begin
                    cnt_next = NW'(1);
                    if (empty_reg)
                    begin
                        low_next  = item_reg.sample;
                        high_next = item_reg.sample;
                    end
                    else
                    begin
                        if (item_reg.sample < low_reg)
                            low_next = item_reg.sample;
                        if (item_reg.sample > high_reg)
                            high_next = item_reg.sample;
                    end
                    empty_next = 1'b0;
                    if (diff < 0)
                    begin
                        below_next = bump(below_reg);
                        state_next = ST_OUT;
                    end
                    else if ({8'b0, diff} >= 42'(span))
                    begin
                        above_next = bump(above_reg);
                        state_next = ST_OUT;
                    end
                    else
                        dreq.start = 1'b1;
                end
                else if (drsp.done)
                begin
                    ptr_next   = AW'(drsp.quotient);
                    state_next = ST_ARD;
                end
            end
            ST_ARD:
            begin
                state_next = ST_AWR;
            end
            ST_AWR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = bump(ram_rdata);
                state_next = ST_OUT;
            end
            ST_RRD:
            begin
                ptr_next = AW'(item_reg.bin_select);
                if ({1'b0, item_reg.bin_select} < 9'(n_eff)
                    && 32'(item_reg.bin_select) < 32'(MAX_BINS))
                    state_next = ST_RDAT;
                else
                    state_next = ST_OUT;
            end
            ST_RDAT:
            begin
                state_next = ST_OUT;
            end
            ST_SWALK:
            begin
                if (cnt_reg == n_eff)
                    state_next = ST_SLAST;
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    sum_next   = sum_add[32] ? '1 : sum_add[31:0];
                    first_next = 1'b0;
                    if (first_reg || ram_rdata > peak_reg)
                        peak_next = ram_rdata;
                    if (first_reg || ram_rdata < flo_reg)
                        flo_next = ram_rdata;
                end
                else
                begin
                    peak_next = '0;
                    flo_next  = '0;
                end
            end
            ST_SLAST:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                res_next.bin_value       = '0;
                res_next.range_error     = 1'b0;
                res_next.sum_of_bins     = '0;
                res_next.peak_bin        = '0;
                res_next.floor_bin       = '0;
                res_next.underflow_total = clamp32(below_reg);
                res_next.overflow_total  = clamp32(above_reg);
                res_next.smallest_sample = low_reg;
                res_next.largest_sample  = high_reg;
                res_next.empty_flag      = empty_reg;
                case (item_reg.opcode)
                    fbh_pkg::OP_READ:
                    begin
                        if ({1'b0, item_reg.bin_select} < 9'(n_eff)
                            && 32'(item_reg.bin_select) < 32'(MAX_BINS))
                            res_next.bin_value = c32;
                        else
                            res_next.range_error = 1'b1;
                    end
                    fbh_pkg::OP_SUMMARY:
                    begin
                        res_next.sum_of_bins = sum_reg;
                        res_next.peak_bin    = clamp32(peak_reg);
                        res_next.floor_bin   = clamp32(flo_reg);
                    end
                    default:
                    begin
                    end
                endcase
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_SWEEP && ptr_reg == AW'(MAX_BINS - 1)
            && item_reg.opcode == fbh_pkg::OP_CLEAR && first_reg)
        begin
            state_next = ST_OUT;
            first_next = 1'b0;
        end

        if (clear_req)
        begin
            state_next  = ST_SWEEP;
            ptr_next    = '0;
            first_next  = 1'b0;
            low_next    = '0;
            high_next   = '0;
            empty_next  = 1'b1;
            below_next  = '0;
            above_next  = '0;
        end
    end

    assign in_ch.ready     = (state_reg == ST_IDLE) && !clear_req
                             && !(ovalid_reg && !out_ch.ready);
    assign out_ch.valid    = ovalid_reg;
    assign out_ch.payload  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            first_reg  <= 1'b0;
            origin_reg <= '0;
            width_reg  <= 31'd65536;
            nbins_reg  <= 9'd256;
            low_reg    <= '0;
            high_reg   <= '0;
            empty_reg  <= 1'b1;
            below_reg  <= '0;
            above_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            first_reg  <= first_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            empty_reg  <= empty_next;
            below_reg  <= below_next;
            above_reg  <= above_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fbh_pkg::CFG_ORIGIN: origin_reg <= cfg_data;
                    fbh_pkg::CFG_WIDTH:  width_reg  <= cfg_data[30:0];
                    fbh_pkg::CFG_BINS:   nbins_reg  <= cfg_data[8:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        peak_reg <= peak_next;
        flo_reg  <= flo_next;
        res_reg  <= res_next;
        if (in_ch.valid && in_ch.ready)
            item_reg <= in_ch.payload;
    end

    property p_one_item;
        @(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready;
    endproperty
    assert property (p_one_item) else $error("Second transfer taken while busy.");

    property p_out_from_out_state;
        @(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_OUT;
    endproperty
    assert property (p_out_from_out_state) else $error("Result raised outside output step.");

    property p_empty_marks;
        @(posedge clk) disable iff (!rst_n)
        empty_reg |-> (low_reg == '0 && high_reg == '0);
    endproperty
    assert property (p_empty_marks) else $error("Marks set while empty.");

    property p_marks_order;
        @(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (low_reg <= high_reg);
    endproperty
    assert property (p_marks_order) else $error("Low mark above high mark.");
endmodule

// ----- tb/sv/tb_fixed_bin_histogram_core.sv -----
// Testbench for the fixed-bin histogram core: random and directed items against a predictor.
`timescale 1ns / 1ps
module tb_fixed_bin_histogram_core;
    localparam int NBINS = 256;
    localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    fbh_if #(.payload_t(fbh_pkg::item_t)) in_ch ();
    fbh_if #(.payload_t(fbh_pkg::result_t)) out_ch ();

    fixed_bin_histogram_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic signed [31:0] m_origin;
    logic [30:0] m_width;
    logic [8:0] m_bins;
    logic [31:0] m_store [NBINS];
    logic signed [31:0] m_low, m_high;
    logic m_empty;
    logic [31:0] m_below, m_above;

    fbh_pkg::item_t pending_items[$];
    fbh_pkg::result_t expected_results[$];
    int errors = 0;
    int drv_gap = 0;
    int mon_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == CMAX) ? c : c + 1;
    endfunction

    function automatic void wipe_stats();
        for (int i = 0; i < NBINS; i++) m_store[i] = '0;
        m_low = 0;
        m_high = 0;
        m_empty = 1'b1;
        m_below = 0;
        m_above = 0;
    endfunction

    function automatic void histogram_step(fbh_pkg::item_t it);
        fbh_pkg::result_t r;
        longint n, w, s, org, top, k;
        logic [32:0] acc;
        n = (m_bins > NBINS) ? NBINS : m_bins;
        w = (m_width == 0) ? 1 : m_width;
        org = m_origin;
        s = it.sample;
        r = '0;
        case (it.opcode)
            fbh_pkg::OP_ADD:
            begin
                if (m_empty || it.sample < m_low) m_low = it.sample;
                if (m_empty || it.sample > m_high) m_high = it.sample;
                m_empty = 1'b0;
                top = org + n * w;
                if (s < org) m_below = bump(m_below);
                else if (s >= top) m_above = bump(m_above);
                else
                begin
                    k = (s - org) / w;
                    m_store[k] = bump(m_store[k]);
                end
            end
            fbh_pkg::OP_READ:
            begin
                if (it.bin_select < n) r.bin_value = m_store[it.bin_select];
                else r.range_error = 1'b1;
            end
            fbh_pkg::OP_SUMMARY:
            begin
                if (n > 0)
                begin
                    acc = '0;
                    r.peak_bin = m_store[0];
                    r.floor_bin = m_store[0];
                    for (int j = 0; j < n; j++)
                    begin
                        acc = acc + m_store[j];
                        if (acc[32]) acc = {1'b0, CMAX};
                        if (m_store[j] > r.peak_bin) r.peak_bin = m_store[j];
                        if (m_store[j] < r.floor_bin) r.floor_bin = m_store[j];
                    end
                    r.sum_of_bins = acc[31:0];
                end
            end
            default: wipe_stats();
        endcase
        r.underflow_total = m_below;
        r.overflow_total = m_above;
        r.smallest_sample = m_low;
        r.largest_sample = m_high;
        r.empty_flag = m_empty;
        expected_results.push_back(r);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            histogram_step(in_ch.payload);
            void'(pending_items.pop_front());
        end
        if (!(in_ch.valid && !in_ch.ready))
        begin
            if (drv_gap > 0)
            begin
                drv_gap <= drv_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_items[0];
                drv_gap <= pick_gap();
            end
            else in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        fbh_pkg::result_t g, e;
        if (out_ch.valid && out_ch.ready)
        begin
            g = out_ch.payload;
            if (expected_results.size() == 0) report("unexpected result", 0, 0);
            else
            begin
                e = expected_results.pop_front();
                if (g.bin_value !== e.bin_value) report("bin_value", g.bin_value, e.bin_value);
                if (g.range_error !== e.range_error)
                    report("range_error", g.range_error, e.range_error);
                if (g.underflow_total !== e.underflow_total)
                    report("underflow_total", g.underflow_total, e.underflow_total);
                if (g.overflow_total !== e.overflow_total)
                    report("overflow_total", g.overflow_total, e.overflow_total);
                if (g.smallest_sample !== e.smallest_sample)
                    report("smallest_sample", g.smallest_sample, e.smallest_sample);
                if (g.largest_sample !== e.largest_sample)
                    report("largest_sample", g.largest_sample, e.largest_sample);
                if (g.empty_flag !== e.empty_flag)
                    report("empty_flag", g.empty_flag, e.empty_flag);
                if (g.sum_of_bins !== e.sum_of_bins)
                    report("sum_of_bins", g.sum_of_bins, e.sum_of_bins);
                if (g.peak_bin !== e.peak_bin) report("peak_bin", g.peak_bin, e.peak_bin);
                if (g.floor_bin !== e.floor_bin) report("floor_bin", g.floor_bin, e.floor_bin);
            end
        end
        if (mon_gap > 0)
        begin
            mon_gap <= mon_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) mon_gap <= pick_gap();
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("fixed_bin_histogram_core: mismatch");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fbh_pkg::CFG_ORIGIN: m_origin = val;
            fbh_pkg::CFG_WIDTH: m_width = val[30:0];
            fbh_pkg::CFG_BINS: m_bins = val[8:0];
            default: ;
        endcase
        if (idx <= fbh_pkg::CFG_BINS) wipe_stats();
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
        repeat (NBINS + 50) @(posedge clk);
    endtask

    function automatic fbh_pkg::item_t make_item(logic [1:0] op, logic [31:0] s,
                                                 logic [7:0] sel);
        fbh_pkg::item_t it;
        it.opcode = op;
        it.sample = s;
        it.bin_select = sel;
        return it;
    endfunction

    function automatic logic [31:0] near_sample();
        longint v;
        v = longint'(m_origin) + longint'($urandom_range(0, 300)) * (m_width == 0 ? 1 : m_width)
            / 256 * ((m_bins == 0) ? 1 : m_bins) / 256 + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 3) == 0) v = longint'(m_origin) - $urandom_range(0, 3);
        return v[31:0];
    endfunction

    function automatic fbh_pkg::item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return make_item(fbh_pkg::OP_ADD,
                             ($urandom_range(0, 9) == 0) ? $urandom : near_sample(),
                             8'($urandom));
        if (r < 85) return make_item(fbh_pkg::OP_READ, $urandom, 8'($urandom));
        if (r < 97) return make_item(fbh_pkg::OP_SUMMARY, $urandom, 8'($urandom));
        return make_item(fbh_pkg::OP_CLEAR, $urandom, 8'($urandom));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        m_origin = 0;
        m_width = 31'd65536;
        m_bins = 9'd256;
        wipe_stats();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (NBINS + 10) @(posedge clk);

        pending_items.push_back(make_item(fbh_pkg::OP_SUMMARY, 0, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h8000_0000, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h7FFF_FFFF, 8'hFF));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h0000_0000, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h00FF_FFFF, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h0100_0000, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'hFFFF_FFFF, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_READ, 0, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_READ, 0, 8'hFF));
        pending_items.push_back(make_item(fbh_pkg::OP_SUMMARY, 0, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_CLEAR, 32'hFFFF_FFFF, 8'hFF));
        pending_items.push_back(make_item(fbh_pkg::OP_SUMMARY, 0, 0));
        drain();

        write_reg(fbh_pkg::CFG_BINS, 32'd0);
        write_reg(fbh_pkg::CFG_WIDTH, 32'd0);
        write_reg(fbh_pkg::CFG_ORIGIN, 32'h8000_0000);
        write_reg(2'd3, 32'hFFFF_FFFF);
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h8000_0000, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h1234_5678, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_READ, 0, 8'h00));
        pending_items.push_back(make_item(fbh_pkg::OP_SUMMARY, 0, 0));
        drain();

        write_reg(fbh_pkg::CFG_BINS, 32'h1FF);
        write_reg(fbh_pkg::CFG_WIDTH, 32'h7FFF_FFFF);
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_ADD, 32'h8000_0001, 0));
        pending_items.push_back(make_item(fbh_pkg::OP_READ, 0, 8'h01));
        pending_items.push_back(make_item(fbh_pkg::OP_SUMMARY, 0, 0));
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(fbh_pkg::CFG_ORIGIN, (ph == 0) ? 32'h7FFF_FFF0 : $urandom_range(0, 1) ?
                      -$urandom_range(0, 32'h0010_0000) : $urandom);
            write_reg(fbh_pkg::CFG_WIDTH, (ph == 1) ? 32'd1 : (ph == 2) ? 32'h7FFF_FFFF :
                      $urandom_range(1, 32'h0002_0000));
            write_reg(fbh_pkg::CFG_BINS, (ph == 3) ? 32'd1 : (ph == 4) ? 32'd256 :
                      $urandom_range(1, 300));
            for (int i = 0; i < 200; i++) pending_items.push_back(random_item());
            drain();
        end

        if (errors == 0)
            $display("fixed_bin_histogram_core: match");
        else
            $display("fixed_bin_histogram_core: mismatch");
        $finish;
    end
endmodule
